// ===== rtl/pft_pkg.sv =====
// shared constants and types of the polygon fan triangulator
`default_nettype none

package pft_pkg;

  // largest number of index words per vertex
  localparam int MAX_STRIDE = 8;
  // significant bits of an index word
  localparam int INDEX_BITS = 32;

  // fixed field widths
  localparam int IDX_W  = 32;
  localparam int CFG_W  = 4;
  localparam int CORN_W = 2;

  // derived widths
  localparam int WORD_W = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
  localparam int POS_W  = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
  localparam int MEM_DEPTH = 3 * MAX_STRIDE;
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  // corner codes
  localparam logic [CORN_W-1:0] CORNER_BASE  = 2'd0;
  localparam logic [CORN_W-1:0] CORNER_PRIOR = 2'd1;
  localparam logic [CORN_W-1:0] CORNER_CURR  = 2'd2;

  // buffer select codes
  localparam logic [1:0] BUF_A = 2'd0;
  localparam logic [1:0] BUF_B = 2'd1;
  localparam logic [1:0] BUF_C = 2'd2;

  // complete vertices seen in the current polygon
  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_BASE = 2'd1;
  localparam logic [1:0] SEEN_FAN  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } pft_state_t;

endpackage : pft_pkg

`default_nettype wire

// ===== rtl/polygon_fan_triangulator_unit.sv =====
// top level of the polygon fan triangulator: vertex gathering and triangle emission
`default_nettype none

// usage
// - in_* carries one index word per transfer; in_tlast marks the last word of
//   a polygon. vertex_stride words form one vertex
// - out_* carries one index word of an emitted triangle per transfer, its
//   corner (base, prior, current) in out_tuser and out_tlast on the final word
// - cfg_* writes vertex_stride (0 acts as 1, above the maximum acts as the
//   maximum); a write abandons the polygon being gathered. cfg_ready is high
// - a word that completes the third or a later vertex starts the emission of
//   3*stride words, one word a cycle from the single-port vertex store while
//   the receiver keeps up. in_tready is low during emission
// - after the completing transfer, the first word enters the output register
// - when the receiver stalls, the output register holds its word and the
//   emission sequencer waits; a waiting word does not block the next input
// - three vertex buffers share one store and swap roles by pointer, so no
//   copy pass is needed
// - reset (rst_n low, synchronous) empties the output register, sets the
//   stride to one and starts a fresh polygon; stored words need no clearing

module polygon_fan_triangulator_unit (
  input  wire                      clk,
  input  wire                      rst_n,
  // input stream
  input  wire                      in_tvalid,
  output logic                     in_tready,
  input  wire  [pft_pkg::IDX_W-1:0] in_tdata,   // [31:0] index_word
  input  wire                      in_tlast,   // polygon_end
  // result stream
  output logic                     out_tvalid,
  input  wire                      out_tready,
  output logic [pft_pkg::IDX_W-1:0] out_tdata,  // [31:0] out_index
  output logic [pft_pkg::CORN_W-1:0] out_tuser, // [1:0] corner
  output logic                     out_tlast,  // triangle_last
  // configuration write
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  [pft_pkg::CFG_W-1:0] cfg_data    // [3:0] vertex_stride
);
  import pft_pkg::*;

  // sequencer
  pft_state_t state_r, state_nxt;

  // stride kept as last word position of a vertex
  logic [POS_W-1:0] smax_r;
  logic [POS_W-1:0] pos_r;
  logic [1:0]       seen_r;

  // buffer role pointers
  logic [1:0] base_sel_r, prior_sel_r, gath_sel_r;

  // emission counters
  logic [CORN_W-1:0] em_corner_r;
  logic [POS_W-1:0]  em_idx_r;

  // output register
  logic                  out_valid_r;
  logic [WORD_W-1:0]     out_word_r;
  logic [CORN_W-1:0]     out_corner_r;
  logic                  out_last_r;

  // vertex store, three buffers of MAX_STRIDE words
  logic [WORD_W-1:0] mem [MEM_DEPTH];

  logic              in_xfer, cfg_xfer, out_free;
  logic              vtx_done, em_load, em_final;
  logic [1:0]        em_sel;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [POS_W-1:0]  cfg_smax;

  assign in_xfer  = in_tvalid && in_tready;
  assign cfg_xfer = cfg_valid && cfg_ready;
  assign out_free = !out_valid_r || out_tready;
  assign vtx_done = (pos_r == smax_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && vtx_done && (seen_r == SEEN_FAN)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (em_load && em_final) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    em_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_EMIT: em_load   = out_free;
      default: in_tready = 1'b0;
    endcase
  end

  assign cfg_ready = 1'b1;

  // which buffer the current corner reads
  always_comb begin
    unique case (em_corner_r)
      CORNER_BASE:  em_sel = base_sel_r;
      CORNER_PRIOR: em_sel = prior_sel_r;
      default:      em_sel = gath_sel_r;
    endcase
  end

  assign em_final = (em_corner_r == CORNER_CURR) && (em_idx_r == smax_r);

  assign wr_addr = ADDR_W'(ADDR_W'(gath_sel_r) * ADDR_W'(MAX_STRIDE) + ADDR_W'(pos_r));
  assign rd_addr = ADDR_W'(ADDR_W'(em_sel) * ADDR_W'(MAX_STRIDE) + ADDR_W'(em_idx_r));

  // stride clamp on write
  always_comb begin
    priority if (cfg_data == '0) begin
      cfg_smax = '0;
    end else if (int'(cfg_data) > MAX_STRIDE) begin
      cfg_smax = POS_W'(MAX_STRIDE - 1);
    end else begin
      cfg_smax = POS_W'(cfg_data - CFG_W'(1));
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      smax_r      <= '0;
      pos_r       <= '0;
      seen_r      <= SEEN_NONE;
      base_sel_r  <= BUF_A;
      prior_sel_r <= BUF_B;
      gath_sel_r  <= BUF_C;
      em_corner_r <= CORNER_BASE;
      em_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_xfer) begin
        // new stride abandons the polygon in progress
        smax_r <= cfg_smax;
        pos_r  <= '0;
        seen_r <= SEEN_NONE;
      end else if (in_xfer) begin
        if (vtx_done) begin
          pos_r <= '0;
          unique case (seen_r)
            SEEN_NONE: begin
              base_sel_r <= gath_sel_r;
              gath_sel_r <= (gath_sel_r == BUF_C) ? BUF_A : gath_sel_r + 2'd1;
              seen_r     <= SEEN_BASE;
            end
            SEEN_BASE: begin
              prior_sel_r <= gath_sel_r;
              // the one buffer neither base nor this vertex
              gath_sel_r  <= 2'b11 ^ base_sel_r ^ gath_sel_r;
              seen_r      <= SEEN_FAN;
            end
            default: begin
              em_corner_r <= CORNER_BASE;
              em_idx_r    <= '0;
            end
          endcase
        end else begin
          pos_r <= pos_r + POS_W'(1);
        end
        if (in_tlast) begin
          pos_r  <= '0;
          seen_r <= SEEN_NONE;
        end
      end

      if (em_load) begin
        if (em_idx_r == smax_r) begin
          em_idx_r    <= '0;
          em_corner_r <= em_corner_r + CORN_W'(1);
        end else begin
          em_idx_r <= em_idx_r + POS_W'(1);
        end
        if (em_final) begin
          // current vertex becomes the prior one, old prior buffer is free
          prior_sel_r <= gath_sel_r;
          gath_sel_r  <= prior_sel_r;
        end
      end

      if (em_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // vertex store and output payload, read data lands in the output register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mem[wr_addr] <= in_tdata[WORD_W-1:0];
    end
    if (em_load) begin
      out_word_r   <= mem[rd_addr];
      out_corner_r <= em_corner_r;
      out_last_r   <= em_final;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = IDX_W'(out_word_r);
  assign out_tuser  = out_corner_r;
  assign out_tlast  = out_last_r;

endmodule : polygon_fan_triangulator_unit

`default_nettype wire

// ===== rtl/pft_checker.sv =====
// port-level checker of the polygon fan triangulator and its bind
`default_nettype none

module pft_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_tvalid,
  input wire                        in_tready,
  input wire                        out_tvalid,
  input wire                        out_tready,
  input wire [pft_pkg::IDX_W-1:0]   out_tdata,
  input wire [pft_pkg::CORN_W-1:0]  out_tuser,
  input wire                        out_tlast
);
  import pft_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output word changed while stalled");

  a_corner_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == CORNER_BASE) || (out_tuser == CORNER_PRIOR)
      || (out_tuser == CORNER_CURR))
    else $error("corner code out of range");

  a_last_on_current: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == CORNER_CURR)
    else $error("triangle end outside the current corner");

  // emission only starts from an accepted word
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid && in_tready))
    else $error("input ready dropped without a transfer");

endmodule : pft_checker

bind polygon_fan_triangulator_unit pft_checker u_pft_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench of the polygon fan triangulator: stream stimulus, fan prediction, checks
`timescale 1ns / 1ps

module testbench;
  import pft_pkg::*;

  // run length guard, far above the slowest correct run
  localparam int LIMIT_CYCLES = 500000;
  // receiver hold-off that fills the block and stalls its input
  localparam int LONG_HOLD = 300;
  // settling cycles after the last result before a stride write or the end
  localparam int SETTLE_CYCLES = 8;

  // one input transfer: index word and polygon end flag
  typedef struct packed {
    logic [IDX_W-1:0] word;
    logic             last;
  } poly_word_t;

  // one result transfer: triangle index word, its corner, triangle end flag
  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [CORN_W-1:0] corner;
    logic              last;
  } tri_word_t;

  // shapes of generated polygons
  typedef enum int {
    SHAPE_CLEAN,
    SHAPE_TRUNCATED,
    SHAPE_NOISE
  } poly_shape_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // block ports
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IDX_W-1:0]  in_tdata = '0;     // [31:0] index_word
  logic              in_tlast = 1'b0;   // polygon_end
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [IDX_W-1:0]  out_tdata;         // [31:0] out_index
  logic [CORN_W-1:0] out_tuser;         // [1:0] corner
  logic              out_tlast;         // triangle_last
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;     // [3:0] vertex_stride

  // words waiting to be offered, and triangle words still to arrive
  poly_word_t pending_words[$];
  tri_word_t  tri_words_due[$];

  // driver bookkeeping: word on the bus, words offered and words taken
  poly_word_t bus_word;
  int unsigned offered_cnt = 0;
  int unsigned taken_cnt = 0;
  int          tx_gap = 0;

  // receiver bookkeeping, long hold requested by the stimulus process
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int          rx_hold = 0;
  int          rx_gap = 0;

  // random idling on both sides, switched off for the closing stretch
  bit idle_on = 1'b1;

  int unsigned fails = 0;
  int unsigned cycles = 0;
  tri_word_t   seen_word;
  tri_word_t   due_word;

  // predicted state of the block
  logic [CFG_W-1:0] stride_reg;
  logic [IDX_W-1:0] fan_base   [MAX_STRIDE];
  logic [IDX_W-1:0] fan_prior  [MAX_STRIDE];
  logic [IDX_W-1:0] fan_gather [MAX_STRIDE];
  logic [POS_W-1:0] gather_pos;
  logic [1:0]       vert_count;

  polygon_fan_triangulator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stride the block really uses: zero acts as one, oversize is clamped
  function automatic int used_stride(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_STRIDE) return MAX_STRIDE;
    return int'(v);
  endfunction

  // a stride write abandons the polygon in progress
  function automatic void take_stride(input logic [CFG_W-1:0] v);
    stride_reg = v;
    gather_pos = '0;
    vert_count = SEEN_NONE;
  endfunction

  // queue the words of one triangle corner
  function automatic void queue_corner(input logic [IDX_W-1:0] v [MAX_STRIDE],
                                       input int s, input logic [CORN_W-1:0] c);
    tri_word_t t;
    for (int i = 0; i < s; i++) begin
      t.index  = v[i];
      t.corner = c;
      t.last   = (c == CORNER_CURR) && (i == s - 1);
      tri_words_due.push_back(t);
    end
  endfunction

  // one accepted word: gather, close a vertex, emit a fan triangle
  function automatic void fan_step(input poly_word_t w);
    int s;
    int pos;
    s = used_stride(stride_reg);
    pos = int'(gather_pos);
    fan_gather[pos] = w.word;
    pos++;
    if (pos >= s) begin
      if (vert_count == SEEN_NONE) begin
        fan_base = fan_gather;
        vert_count = SEEN_BASE;
      end else if (vert_count == SEEN_BASE) begin
        fan_prior = fan_gather;
        vert_count = SEEN_FAN;
      end else begin
        queue_corner(fan_base, s, CORNER_BASE);
        queue_corner(fan_prior, s, CORNER_PRIOR);
        queue_corner(fan_gather, s, CORNER_CURR);
        fan_prior = fan_gather;
      end
      pos = 0;
    end
    // polygon end drops a half-gathered vertex and restarts the fan
    if (w.last) begin
      pos = 0;
      vert_count = SEEN_NONE;
    end
    gather_pos = pos[POS_W-1:0];
  endfunction

  // driver: offers pending words at the falling edge, holds a word until taken
  always @(negedge clk) begin
    if (offered_cnt != taken_cnt) begin
      // word still waiting for its transfer
    end else if (tx_gap > 0) begin
      tx_gap--;
      in_tvalid <= 1'b0;
    end else if (rst_n && pending_words.size() > 0) begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        tx_gap = $urandom_range(1, 19) - 1;
        in_tvalid <= 1'b0;
      end else begin
        bus_word = pending_words.pop_front();
        in_tdata  <= bus_word.word;
        in_tlast  <= bus_word.last;
        in_tvalid <= 1'b1;
        offered_cnt++;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // receiver: random stall bursts, plus the long hold when asked for
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      rx_hold = LONG_HOLD;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(1, 19) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: follows stride writes and input transfers, checks each result
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) take_stride(cfg_data);
      if (in_tvalid && in_tready) begin
        fan_step(bus_word);
        taken_cnt++;
      end
      if (out_tvalid && out_tready) begin
        seen_word.index  = out_tdata;
        seen_word.corner = out_tuser;
        seen_word.last   = out_tlast;
        if (tri_words_due.size() == 0) begin
          $error("result transfer with nothing due: out_index %h corner %0d last %0b",
                 seen_word.index, seen_word.corner, seen_word.last);
          fails++;
        end else begin
          due_word = tri_words_due.pop_front();
          if (seen_word.index !== due_word.index) begin
            $error("out_index expected %h actual %h", due_word.index, seen_word.index);
            fails++;
          end
          if (seen_word.corner !== due_word.corner) begin
            $error("corner expected %0d actual %0d", due_word.corner, seen_word.corner);
            fails++;
          end
          if (seen_word.last !== due_word.last) begin
            $error("triangle_last expected %0b actual %0b", due_word.last, seen_word.last);
            fails++;
          end
        end
      end
    end
  end

  // guard against a hung block
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_word(input logic [IDX_W-1:0] w, input logic last);
    poly_word_t p;
    p.word = w;
    p.last = last;
    pending_words.push_back(p);
  endtask

  // random word, with extra weight on the all-zero and all-one extremes
  function automatic logic [IDX_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // wait until every word is taken and every result in, then let the block settle
  task automatic settle();
    @(posedge clk);
    while (pending_words.size() != 0 || offered_cnt != taken_cnt ||
           tri_words_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stride write over the configuration channel, block idle
  task automatic write_stride(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly clean polygons with random content, some cut short, some stray words
  task automatic random_words(input logic [CFG_W-1:0] stride_val, input int budget);
    int s;
    int verts;
    int extra;
    int made;
    int roll;
    poly_shape_t shape;
    s = used_stride(stride_val);
    made = 0;
    while (made < budget) begin
      roll = $urandom_range(0, 9);
      shape = (roll < 8) ? SHAPE_CLEAN : (roll == 8) ? SHAPE_TRUNCATED : SHAPE_NOISE;
      case (shape)
        SHAPE_CLEAN: begin
          verts = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
          // wide vertices keep to short polygons
          if (s > 4 && verts > 3) verts = 3;
          for (int i = 0; i < verts * s; i++)
            add_word(pick_word(), i == verts * s - 1);
          made += verts * s;
        end
        SHAPE_TRUNCATED: begin
          verts = $urandom_range(0, 4);
          extra = (s > 1) ? $urandom_range(1, s - 1) : 0;
          for (int i = 0; i < verts * s + extra; i++)
            add_word(pick_word(), (extra > 0) && (i == verts * s + extra - 1));
          made += verts * s + extra;
        end
        default: begin
          extra = $urandom_range(1, 3);
          for (int i = 0; i < extra; i++)
            add_word(pick_word(), 1'($urandom_range(0, 1)));
          made += extra;
        end
      endcase
    end
  endtask

  // stimulus and run control
  initial begin : stimulus
    int budget;
    int left;

    // predictor state after reset
    take_stride(4'd1);
    foreach (fan_base[i]) begin
      fan_base[i] = '0;
      fan_prior[i] = '0;
      fan_gather[i] = '0;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, stride one from reset
    // single vertex and two vertices give no triangle
    add_word(32'h0000_0000, 1'b1);
    add_word(32'h0000_0001, 1'b0);
    add_word(32'h0000_0002, 1'b1);
    // smallest fan, extreme words
    add_word(32'hFFFF_FFFF, 1'b0);
    add_word(32'h0000_0000, 1'b0);
    add_word(32'h8000_0001, 1'b1);
    // five vertices give three triangles sharing the base
    add_word(32'h1234_5678, 1'b0);
    add_word(32'hFFFF_FFFF, 1'b0);
    add_word(32'h0000_0000, 1'b0);
    add_word(32'hA5A5_A5A5, 1'b0);
    add_word(32'h5A5A_5A5A, 1'b1);
    settle();

    // three words per vertex, then a trailing vertex cut short by polygon end
    write_stride(4'd3);
    add_word(32'hFFFF_FFFF, 1'b0);
    add_word(32'h0000_0000, 1'b0);
    add_word(32'hAAAA_AAAA, 1'b0);
    add_word(32'h5555_5555, 1'b0);
    add_word(32'hFFFF_FFFF, 1'b0);
    add_word(32'h0000_0001, 1'b0);
    add_word(32'h8000_0000, 1'b0);
    add_word(32'h7FFF_FFFF, 1'b0);
    add_word(32'h0000_0000, 1'b0);
    add_word(32'hDEAD_BEEF, 1'b0);
    add_word(32'hFFFF_FFFF, 1'b1);
    // a vertex and a word left open, abandoned by the next stride write
    add_word(32'h0F0F_0F0F, 1'b0);
    add_word(32'hF0F0_F0F0, 1'b0);
    add_word(32'h3333_3333, 1'b0);
    add_word(32'hCCCC_CCCC, 1'b0);
    settle();

    // random part: receiver held off long while the sender keeps offering
    write_stride(4'd2);
    hold_req++;
    random_words(4'd2, 15);
    settle();

    // stride zero behaves as one
    write_stride(4'd0);
    random_words(4'd0, 12);
    settle();

    // widest vertex, with a pause until every due result is in
    write_stride(4'd8);
    random_words(4'd8, 8);
    settle();
    random_words(4'd8, 8);
    settle();

    // oversize stride is clamped to the maximum
    write_stride(4'd15);
    random_words(4'd15, 8);
    settle();

    write_stride(4'd5);
    random_words(4'd5, 8);
    settle();

    // two random strides, any of the sixteen codes
    for (int k = 0; k < 2; k++) begin
      budget = $urandom_range(0, 15);
      write_stride(budget[CFG_W-1:0]);
      random_words(budget[CFG_W-1:0], 6);
      settle();
    end

    // closing stretch at full rate on both sides
    idle_on = 1'b0;
    write_stride(4'd3);
    random_words(4'd3, 10);
    settle();

    left = tri_words_due.size();
    if (left != 0) begin
      $error("%0d triangle words never arrived", left);
      fails++;
    end
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pft_pkg.sv
rtl/polygon_fan_triangulator_unit.sv
rtl/pft_checker.sv
tb/testbench.sv
